@@ hdl/allocation_tracking_table_defines.svh @@
// Assertion macros shared by the allocation tracking table modules.
`ifndef ALLOCATION_TRACKING_TABLE_DEFINES_SVH
`define ALLOCATION_TRACKING_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define ATT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define ATT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/att_pkg.sv @@
// Shared types, codes and helpers of the allocation tracking table.
package att_pkg;

	localparam int DEF_SLOTS     = 64;
	localparam int DEF_ADDR_BITS = 32;
	localparam int DEF_SIZE_BITS = 32;
	localparam int Q_DEPTH       = 2;

	localparam logic [1:0] CMD_ALLOC   = 2'd0;
	localparam logic [1:0] CMD_FREE    = 2'd1;
	localparam logic [1:0] CMD_INSPECT = 2'd2;

	typedef logic [2:0] status_t;
	localparam status_t ST_OK          = 3'd0;
	localparam status_t ST_NULL_ALLOC  = 3'd1;
	localparam status_t ST_FULL        = 3'd2;
	localparam status_t ST_NULL_FREE   = 3'd3;
	localparam status_t ST_DOUBLE_FREE = 3'd4;

	typedef enum logic [1:0] {
		K_REPORT,
		K_ALLOC,
		K_FREE,
		K_INSPECT
	} op_kind_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_PEEK,
		S_WRITE,
		S_RESULT
	} back_state_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] address;
		logic [31:0] alloc_size;
		logic [15:0] source_line;
		logic [5:0]  slot_index;
	} in_item_t;

	typedef struct packed {
		status_t     status;
		logic [47:0] total_allocated;
		logic [47:0] total_freed;
		logic [47:0] leaked_bytes;
		logic        slot_live;
		logic [31:0] slot_size;
		logic [15:0] slot_line;
	} out_item_t;

	typedef struct packed {
		op_kind_t    kind;
		status_t     status;
		logic [31:0] key;
		logic [31:0] size;
		logic [15:0] line;
		logic [5:0]  index;
	} op_t;

	function automatic int field_width(input int bits);
		return (bits < 32) ? bits : 32;
	endfunction

endpackage

@@ hdl/att_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module att_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hdl/att_queue.sv @@
// Short queue of classified operations between front and back.
`include "allocation_tracking_table_defines.svh"

module att_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  att_pkg::op_t  op_in,
	output logic          full,
	input  logic          pop,
	output att_pkg::op_t  op_out,
	output logic          empty
);
	import att_pkg::*;

	localparam int PW = $clog2(Q_DEPTH);
	localparam int CW = $clog2(Q_DEPTH + 1);

	op_t            entry_q [Q_DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  cnt_q;
	logic           do_push;
	logic           do_pop;

	assign full    = (cnt_q == CW'(Q_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign op_out  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= op_in;
		end
	end

	`ATT_ASSERT_NOW(a_q_bound, 1'b1, cnt_q <= CW'(Q_DEPTH), "queue occupancy out of range")
	`ATT_ASSERT_NEXT(a_q_hold, full && !pop, cnt_q == CW'(Q_DEPTH), "full queue lost an entry")

endmodule

@@ hdl/att_front.sv @@
// Front end: accepts items and classifies them into back-end operations.
module att_front #(
	parameter int SLOTS     = att_pkg::DEF_SLOTS,
	parameter int ADDR_BITS = att_pkg::DEF_ADDR_BITS,
	parameter int SIZE_BITS = att_pkg::DEF_SIZE_BITS
) (
	input  logic              push,
	input  att_pkg::in_item_t item,
	output logic              full,
	input  logic              q_full,
	input  logic              clearing,
	output logic              q_push,
	output att_pkg::op_t      q_op
);
	import att_pkg::*;

	localparam int AW = field_width(ADDR_BITS);
	localparam int SW = field_width(SIZE_BITS);

	logic in_range;

	assign full     = q_full || clearing;
	assign q_push   = push && !full;
	assign in_range = {26'd0, item.slot_index} < 32'(SLOTS);

	always_comb begin
		q_op        = '0;
		q_op.kind   = K_REPORT;
		q_op.status = ST_OK;
		q_op.key    = 32'(item.address[AW-1:0]);
		q_op.size   = 32'(item.alloc_size[SW-1:0]);
		q_op.line   = item.source_line;
		q_op.index  = item.slot_index;
		case (item.command)
			CMD_ALLOC: begin
				if (q_op.key == '0) begin
					q_op.status = ST_NULL_ALLOC;
				end else begin
					q_op.kind = K_ALLOC;
				end
			end
			CMD_FREE: begin
				if (q_op.key == '0) begin
					q_op.status = ST_NULL_FREE;
				end else begin
					q_op.kind = K_FREE;
				end
			end
			CMD_INSPECT: begin
				if (in_range) begin
					q_op.kind = K_INSPECT;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

@@ hdl/att_back.sv @@
// Back end: scans the slot memory, updates totals and holds the result.
`include "allocation_tracking_table_defines.svh"

module att_back #(
	parameter int SLOTS     = att_pkg::DEF_SLOTS,
	parameter int ADDR_BITS = att_pkg::DEF_ADDR_BITS,
	parameter int SIZE_BITS = att_pkg::DEF_SIZE_BITS
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   q_empty,
	input  att_pkg::op_t                           q_head,
	output logic                                   q_pop,
	output logic                                   clearing,
	output logic                                   ram_we,
	output logic [$clog2(SLOTS)-1:0]               ram_waddr,
	output logic [att_pkg::field_width(ADDR_BITS)
		+ att_pkg::field_width(SIZE_BITS) + 15:0] ram_wdata,
	output logic                                   ram_re,
	output logic [$clog2(SLOTS)-1:0]               ram_raddr,
	input  logic [att_pkg::field_width(ADDR_BITS)
		+ att_pkg::field_width(SIZE_BITS) + 15:0] ram_rdata,
	output logic                                   empty,
	input  logic                                   pop,
	output att_pkg::out_item_t                     result
);
	import att_pkg::*;

	localparam int AW = field_width(ADDR_BITS);
	localparam int SW = field_width(SIZE_BITS);
	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);

	back_state_t   state_q;
	back_state_t   state_d;
	logic [CW-1:0] cnt_q;
	logic          rd_vld_s1;
	logic [IW-1:0] rd_idx_s1;
	op_t           op_q;
	status_t       status_q;
	logic [IW-1:0] hit_idx_q;
	logic [SW-1:0] hit_bytes_q;
	logic [15:0]   hit_line_q;
	logic          peek_live_q;
	logic [SW-1:0] peek_bytes_q;
	logic [15:0]   peek_line_q;
	logic [47:0]   sum_alloc_q;
	logic [47:0]   sum_freed_q;
	out_item_t     res_q;
	logic          res_vld_q;

	logic [AW-1:0] rd_addr;
	logic [SW-1:0] rd_bytes;
	logic [15:0]   rd_line;
	logic [AW-1:0] match_key;
	logic          hit;
	logic          miss;
	logic          out_free;
	logic          scan_issue;

	assign rd_addr   = ram_rdata[AW+SW+15 -: AW];
	assign rd_bytes  = ram_rdata[SW+15 -: SW];
	assign rd_line   = ram_rdata[15:0];
	assign match_key = (op_q.kind == K_ALLOC) ? '0 : op_q.key[AW-1:0];
	assign hit       = (state_q == S_SCAN) && rd_vld_s1 && (rd_addr == match_key);
	assign miss      = (state_q == S_SCAN) && rd_vld_s1 && (rd_addr != match_key)
		&& (rd_idx_s1 == IW'(SLOTS - 1));
	assign out_free  = !res_vld_q || pop;
	assign empty     = !res_vld_q;
	assign result    = res_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (cnt_q == CW'(SLOTS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (!q_empty) begin
					case (q_head.kind)
						K_ALLOC:   state_d = S_SCAN;
						K_FREE:    state_d = S_SCAN;
						K_INSPECT: state_d = S_PEEK;
						default:   state_d = S_RESULT;
					endcase
				end
			end
			S_SCAN: begin
				if (hit) begin
					state_d = S_WRITE;
				end else if (miss) begin
					state_d = S_RESULT;
				end
			end
			S_PEEK:  state_d = S_RESULT;
			S_WRITE: state_d = S_RESULT;
			S_RESULT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		q_pop      = 1'b0;
		clearing   = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = '0;
		ram_wdata  = '0;
		ram_re     = 1'b0;
		ram_raddr  = '0;
		scan_issue = 1'b0;
		case (state_q)
			S_CLEAR: begin
				clearing  = 1'b1;
				ram_we    = 1'b1;
				ram_waddr = cnt_q[IW-1:0];
			end
			S_IDLE: begin
				q_pop = !q_empty;
				if (!q_empty && q_head.kind == K_INSPECT) begin
					ram_re    = 1'b1;
					ram_raddr = IW'(q_head.index);
				end
			end
			S_SCAN: begin
				if (cnt_q < CW'(SLOTS) && !hit) begin
					scan_issue = 1'b1;
					ram_re     = 1'b1;
					ram_raddr  = cnt_q[IW-1:0];
				end
			end
			S_WRITE: begin
				ram_we    = 1'b1;
				ram_waddr = hit_idx_q;
				if (op_q.kind == K_ALLOC) begin
					ram_wdata = {op_q.key[AW-1:0], op_q.size[SW-1:0], op_q.line};
				end else begin
					ram_wdata = {{AW{1'b0}}, hit_bytes_q, hit_line_q};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			cnt_q       <= '0;
			rd_vld_s1   <= 1'b0;
			sum_alloc_q <= '0;
			sum_freed_q <= '0;
			res_vld_q   <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= scan_issue;
			if (state_q == S_CLEAR || scan_issue) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (state_q == S_IDLE) begin
				cnt_q <= '0;
			end
			if (state_q == S_WRITE) begin
				if (op_q.kind == K_ALLOC) begin
					sum_alloc_q <= sum_alloc_q + 48'(op_q.size[SW-1:0]);
				end else begin
					sum_freed_q <= sum_freed_q + 48'(hit_bytes_q);
				end
			end
			if (state_q == S_RESULT && out_free) begin
				res_vld_q <= 1'b1;
			end else if (pop) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= cnt_q[IW-1:0];
		if (q_pop) begin
			op_q         <= q_head;
			status_q     <= q_head.status;
			peek_live_q  <= 1'b0;
			peek_bytes_q <= '0;
			peek_line_q  <= '0;
		end
		if (miss) begin
			status_q <= (op_q.kind == K_ALLOC) ? ST_FULL : ST_DOUBLE_FREE;
		end
		if (hit) begin
			hit_idx_q   <= rd_idx_s1;
			hit_bytes_q <= rd_bytes;
			hit_line_q  <= rd_line;
		end
		if (state_q == S_PEEK) begin
			peek_live_q  <= (rd_addr != '0);
			peek_bytes_q <= rd_bytes;
			peek_line_q  <= rd_line;
		end
		if (state_q == S_RESULT && out_free) begin
			res_q.status          <= status_q;
			res_q.total_allocated <= sum_alloc_q;
			res_q.total_freed     <= sum_freed_q;
			res_q.leaked_bytes    <= sum_alloc_q - sum_freed_q;
			res_q.slot_live       <= peek_live_q;
			res_q.slot_size       <= 32'(peek_bytes_q);
			res_q.slot_line       <= peek_line_q;
		end
	end

	`ATT_ASSERT_NOW(a_we_state, ram_we, state_q == S_CLEAR || state_q == S_WRITE, "stray slot write")
	`ATT_ASSERT_NOW(a_clear_idle, state_q == S_CLEAR, !q_pop && !res_vld_q, "work during clear")
	`ATT_ASSERT_NEXT(a_free_sum, state_q == S_WRITE && op_q.kind == K_FREE, sum_alloc_q == $past(sum_alloc_q), "free moved allocated total")

endmodule

@@ hdl/allocation_tracking_table.sv @@
// Allocation tracking table: top level joining front, queue, back and slot memory.
//
// Input channel: item carries command, address, alloc_size, source_line and
// slot_index; a transfer takes place on a rising edge with push high and full low.
// Result channel: result holds the oldest waiting result while empty is low; a
// transfer takes place on a rising edge with pop high and empty low.
// Every item gives exactly one result, in order of arrival.
// Null and unused commands and an inspect beyond the table skip the slot memory;
// an inspect first reads its slot, and an allocation or a free searches the table
// (ending with a full or double-free status when the table is full or the address
// is unknown). The back end reads the slot memory one slot per cycle through its
// single read port, visiting slots in order up to the first match. The back end
// handles one item at a time, taking no new item until its result is registered.
// Up to two classified items wait between front and back, so input keeps
// flowing while a result waits; when the receiver stalls, the back end holds
// its finished result and the queue fills, then full rises.
// Reset: totals clear at once; the slot memory is then cleared one slot per
// cycle, every slot in turn, with full held high throughout.
module allocation_tracking_table #(
	parameter int SLOTS     = att_pkg::DEF_SLOTS,
	parameter int ADDR_BITS = att_pkg::DEF_ADDR_BITS,
	parameter int SIZE_BITS = att_pkg::DEF_SIZE_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  att_pkg::in_item_t   item,
	output logic                full,
	output logic                empty,
	input  logic                pop,
	output att_pkg::out_item_t  result
);
	import att_pkg::*;

	localparam int DW = field_width(ADDR_BITS) + field_width(SIZE_BITS) + 16;
	localparam int IW = $clog2(SLOTS);

	logic          q_full;
	logic          q_empty;
	logic          q_push;
	logic          q_pop;
	logic          clearing;
	op_t           q_in;
	op_t           q_head;
	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	logic [DW-1:0] ram_wdata;
	logic          ram_re;
	logic [IW-1:0] ram_raddr;
	logic [DW-1:0] ram_rdata;

	att_front #(
		.SLOTS(SLOTS),
		.ADDR_BITS(ADDR_BITS),
		.SIZE_BITS(SIZE_BITS)
	) u_front (
		.push(push),
		.item(item),
		.full(full),
		.q_full(q_full),
		.clearing(clearing),
		.q_push(q_push),
		.q_op(q_in)
	);

	att_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.op_in(q_in),
		.full(q_full),
		.pop(q_pop),
		.op_out(q_head),
		.empty(q_empty)
	);

	att_back #(
		.SLOTS(SLOTS),
		.ADDR_BITS(ADDR_BITS),
		.SIZE_BITS(SIZE_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.q_head(q_head),
		.q_pop(q_pop),
		.clearing(clearing),
		.ram_we(ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_re(ram_re),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

	att_ram #(
		.WIDTH(DW),
		.DEPTH(SLOTS)
	) u_slot_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

endmodule
